// ===== sv/lodsel_pkg.sv =====
`timescale 1ns / 1ps

package lodsel_pkg;

  localparam int NUM_CLUSTERS = 64;
  localparam int NUM_LEVELS   = 4;

  localparam int CL_W      = $clog2(NUM_CLUSTERS);
  localparam int LV_W      = 2;
  localparam int CNT_W     = 3;
  localparam int TGT_W     = 3;
  localparam int POS_W     = 24;
  localparam int DIST_W    = 24;
  localparam int SCALE_W   = 16;
  localparam int HYST_W    = 8;
  localparam int K_W       = HYST_W + 1;
  localparam int S2_W      = 2 * SCALE_W;
  localparam int MAG_W     = POS_W + 1;
  localparam int MA_W      = 25;
  localparam int MB_W      = DIST_W + K_W;
  localparam int PROD_W    = MA_W + MB_W;
  localparam int ACC_W     = 82;
  localparam int PROXY_W   = $clog2(NUM_CLUSTERS + 1);
  localparam int SW_AW     = CL_W + LV_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DW    = SCALE_W;

  typedef enum logic [1:0] {
    KIND_QUERY  = 2'd0,
    KIND_CENTER = 2'd1,
    KIND_SWITCH = 2'd2,
    KIND_COUNT  = 2'd3
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] REG_DIST_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HYST       = 1'b1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(256);
  localparam logic [K_W-1:0]     K_UNITY     = K_W'(256);

  // level -1: original objects shown
  localparam logic signed [TGT_W-1:0] LVL_NONE  = -3'sd1;
  localparam logic [CNT_W-1:0]        MAX_COUNT = CNT_W'(NUM_LEVELS);

  typedef struct packed {
    logic issue;
    logic clr;
    logic shift;
  } mac_op_t;

  typedef struct packed {
    logic rd_en;
    logic center_we;
    logic switch_we;
    logic count_we;
    logic active_we;
    logic switch_re;
  } tbl_ctl_t;

endpackage

// ===== sv/lodsel_mac.sv =====
`timescale 1ns / 1ps

module lodsel_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  lodsel_pkg::mac_op_t                  op,
  input  logic [lodsel_pkg::MA_W-1:0]          a,
  input  logic [lodsel_pkg::MB_W-1:0]          b,
  output logic [lodsel_pkg::ACC_W-1:0]         acc
);
  import lodsel_pkg::*;

  logic [PROD_W-1:0] prod;
  logic              prod_vld;
  logic              prod_clr;
  logic              prod_sh;
  logic [ACC_W-1:0]  addend;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= op.issue;
    end
    prod     <= PROD_W'(a) * PROD_W'(b);
    prod_clr <= op.clr;
    prod_sh  <= op.shift;
  end

  // shifted form carries the upper partial product
  assign addend = prod_sh ? ACC_W'({prod, MA_W'(0)}) : ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (prod_vld) begin
      acc <= prod_clr ? addend : acc + addend;
    end
  end

endmodule

// ===== sv/lodsel_store.sv =====
`timescale 1ns / 1ps

module lodsel_store (
  input  logic                                     clk,
  input  logic                                     rst,
  input  lodsel_pkg::tbl_ctl_t                     ctl,
  input  logic [lodsel_pkg::CL_W-1:0]              cluster,
  input  logic [lodsel_pkg::LV_W-1:0]              level,
  input  logic signed [lodsel_pkg::POS_W-1:0]      pos_x,
  input  logic signed [lodsel_pkg::POS_W-1:0]      pos_y,
  input  logic signed [lodsel_pkg::POS_W-1:0]      pos_z,
  input  logic [lodsel_pkg::DIST_W-1:0]            switch_dist,
  input  logic [lodsel_pkg::CNT_W-1:0]             count_wdata,
  input  logic [lodsel_pkg::CL_W-1:0]              act_addr,
  input  logic signed [lodsel_pkg::TGT_W-1:0]      act_wdata,
  input  logic [lodsel_pkg::SW_AW-1:0]             sw_raddr,
  output logic signed [lodsel_pkg::POS_W-1:0]      ctr_x,
  output logic signed [lodsel_pkg::POS_W-1:0]      ctr_y,
  output logic signed [lodsel_pkg::POS_W-1:0]      ctr_z,
  output logic [lodsel_pkg::CNT_W-1:0]             count_rd,
  output logic signed [lodsel_pkg::TGT_W-1:0]      act_rd,
  output logic [lodsel_pkg::DIST_W-1:0]            sw_rd
);
  import lodsel_pkg::*;

  logic [3*POS_W-1:0]       center_mem [NUM_CLUSTERS];
  logic [DIST_W-1:0]        switch_mem [NUM_CLUSTERS*NUM_LEVELS];
  logic [CNT_W-1:0]         count_mem  [NUM_CLUSTERS];
  logic signed [TGT_W-1:0]  active_mem [NUM_CLUSTERS];

  logic [NUM_CLUSTERS-1:0]  count_vld;
  logic [NUM_CLUSTERS-1:0]  active_vld;

  logic [3*POS_W-1:0]       center_q;
  logic [CNT_W-1:0]         count_q;
  logic signed [TGT_W-1:0]  active_q;
  logic                     count_vq;
  logic                     active_vq;

  always_ff @(posedge clk) begin
    if (ctl.center_we) begin
      center_mem[cluster] <= {pos_x, pos_y, pos_z};
    end
    if (ctl.switch_we) begin
      switch_mem[{cluster, level}] <= switch_dist;
    end
    if (ctl.count_we) begin
      count_mem[cluster] <= count_wdata;
    end
    if (ctl.active_we) begin
      active_mem[act_addr] <= act_wdata;
    end
    if (ctl.rd_en) begin
      center_q <= center_mem[cluster];
      count_q  <= count_mem[cluster];
      active_q <= active_mem[cluster];
    end
    if (ctl.switch_re) begin
      sw_rd <= switch_mem[sw_raddr];
    end
  end

  // count and active entries never written read as their reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      count_vld  <= '0;
      active_vld <= '0;
      count_vq   <= 1'b0;
      active_vq  <= 1'b0;
    end else begin
      if (ctl.count_we) begin
        count_vld[cluster] <= 1'b1;
      end
      if (ctl.active_we) begin
        active_vld[act_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        count_vq  <= count_vld[cluster];
        active_vq <= active_vld[cluster];
      end
    end
  end

  assign ctr_x    = $signed(center_q[3*POS_W-1:2*POS_W]);
  assign ctr_y    = $signed(center_q[2*POS_W-1:POS_W]);
  assign ctr_z    = $signed(center_q[POS_W-1:0]);
  assign count_rd = count_vq ? count_q : '0;
  assign act_rd   = active_vq ? active_q : LVL_NONE;

endmodule

// ===== sv/lod_level_select_hysteresis_unit.sv =====
`timescale 1ns / 1ps

// LOD level selector with hysteresis for 64 clusters. Items are taken one at a
// time. A query examines the cluster's levels from the highest down, up to and
// including the first one that passes (at most the cluster's level count); its
// result then waits for a free output register. Its products come from a
// single 25x33 multiplier-accumulator with a registered product: the squared
// camera distance, the squared scale, their 82-bit product and, per level, the
// scaled threshold and its square are all formed on it in turn. The level scan
// reads one switch distance per level from the table. The result sits in an
// output register, so the next item can be accepted while it waits.
module lod_level_select_hysteresis_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [lodsel_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lodsel_pkg::CFG_DW-1:0]          cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             kind,
  input  logic [lodsel_pkg::CL_W-1:0]            cluster,
  input  logic [lodsel_pkg::LV_W-1:0]            level,
  input  logic signed [lodsel_pkg::POS_W-1:0]    pos_x,
  input  logic signed [lodsel_pkg::POS_W-1:0]    pos_y,
  input  logic signed [lodsel_pkg::POS_W-1:0]    pos_z,
  input  logic [lodsel_pkg::DIST_W-1:0]          switch_dist,
  input  logic [lodsel_pkg::CNT_W-1:0]           count,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [lodsel_pkg::CL_W-1:0]            cluster_out,
  output logic signed [lodsel_pkg::TGT_W-1:0]    sel_level,
  output logic                                   changed,
  output logic [lodsel_pkg::PROXY_W-1:0]         active_proxies
);
  import lodsel_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CENTER = 5'b00010,
    ST_PREP   = 5'b00100,
    ST_LEVEL  = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  localparam int STEP_W = 4;

  // prep sequence
  localparam logic [STEP_W-1:0] P_SCALE = 4'd0;
  localparam logic [STEP_W-1:0] P_SQX   = 4'd1;
  localparam logic [STEP_W-1:0] P_SQY   = 4'd2;
  localparam logic [STEP_W-1:0] P_SQZ   = 4'd3;
  localparam logic [STEP_W-1:0] P_LO    = 4'd5;
  localparam logic [STEP_W-1:0] P_HI    = 4'd6;
  localparam logic [STEP_W-1:0] P_LAST  = 4'd8;
  // per-level sequence
  localparam logic [STEP_W-1:0] L_READ  = 4'd0;
  localparam logic [STEP_W-1:0] L_MULK  = 4'd1;
  localparam logic [STEP_W-1:0] L_TLO   = 4'd3;
  localparam logic [STEP_W-1:0] L_THI   = 4'd4;
  localparam logic [STEP_W-1:0] L_LAST  = 4'd6;

  function automatic logic [MAG_W-1:0] abs_diff(input logic signed [POS_W-1:0] a,
                                                 input logic signed [POS_W-1:0] b);
    logic signed [MAG_W-1:0] d;
    d = $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
    return d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
  endfunction

  state_t                   state;
  logic [STEP_W-1:0]        step;
  logic [CL_W-1:0]          c_r;
  logic signed [POS_W-1:0]  px, py, pz;
  logic [MAG_W-1:0]         mx, my, mz;
  logic [S2_W-1:0]          s2_r;
  logic [MA_W-1:0]          d2hi_r;
  logic [ACC_W-1:0]         lhs_r;
  logic [MB_W-1:0]          t_r;
  logic signed [TGT_W-1:0]  act_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [LV_W-1:0]          lvl;
  logic signed [TGT_W-1:0]  target_r;
  logic [PROXY_W-1:0]       proxy;
  logic [PROXY_W-1:0]       proxy_next;
  logic [SCALE_W-1:0]       scale;
  logic [HYST_W-1:0]        hyst;

  logic                     in_fire;
  logic                     out_free;
  logic                     chg_w;
  logic                     hit;
  logic [K_W-1:0]           k;
  logic [CNT_W-1:0]         count_sat;

  tbl_ctl_t                 tctl;
  logic signed [TGT_W-1:0]  act_wdata;
  logic signed [POS_W-1:0]  ctr_x, ctr_y, ctr_z;
  logic [CNT_W-1:0]         count_rd;
  logic signed [TGT_W-1:0]  act_rd;
  logic [DIST_W-1:0]        sw_rd;

  mac_op_t                  mop;
  logic [MA_W-1:0]          ma;
  logic [MB_W-1:0]          mb;
  logic [ACC_W-1:0]         mac_acc;

  assign in_stall  = (state != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign count_sat = (count > MAX_COUNT) ? MAX_COUNT : count;
  assign chg_w     = (target_r != act_r);
  assign hit       = (lhs_r >= mac_acc);

  // threshold widens below the active level, narrows above it
  always_comb begin
    if (act_r > $signed({1'b0, lvl})) begin
      k = K_UNITY + K_W'(hyst);
    end else if (act_r < $signed({1'b0, lvl})) begin
      k = K_UNITY - K_W'(hyst);
    end else begin
      k = K_UNITY;
    end
  end

  always_comb begin
    proxy_next = proxy;
    if (state == ST_CENTER) begin
      if (act_rd >= 0 && proxy != '0) begin
        proxy_next = proxy - 1'b1;
      end
    end else if (state == ST_DONE && out_free && chg_w) begin
      if (act_r < 0 && target_r >= 0) begin
        proxy_next = proxy + 1'b1;
      end else if (act_r >= 0 && target_r < 0 && proxy != '0) begin
        proxy_next = proxy - 1'b1;
      end
    end
  end

  always_comb begin
    tctl           = '0;
    tctl.rd_en     = in_fire;
    tctl.center_we = in_fire && (kind == KIND_CENTER);
    tctl.switch_we = in_fire && (kind == KIND_SWITCH) && ({1'b0, level} < 3'(NUM_LEVELS));
    tctl.count_we  = in_fire && (kind == KIND_COUNT);
    tctl.active_we = (state == ST_CENTER) || (state == ST_DONE && out_free && chg_w);
    tctl.switch_re = (state == ST_LEVEL) && (step == L_READ);
    act_wdata      = (state == ST_DONE) ? target_r : LVL_NONE;
  end

  always_comb begin
    mop = '0;
    ma  = '0;
    mb  = '0;
    if (state == ST_PREP) begin
      unique case (step)
        P_SCALE: begin
          mop = '{issue: 1'b1, clr: 1'b1, shift: 1'b0};
          ma  = MA_W'(scale);
          mb  = MB_W'(scale);
        end
        P_SQX: begin
          mop = '{issue: 1'b1, clr: 1'b1, shift: 1'b0};
          ma  = mx;
          mb  = MB_W'(mx);
        end
        P_SQY: begin
          mop = '{issue: 1'b1, clr: 1'b0, shift: 1'b0};
          ma  = my;
          mb  = MB_W'(my);
        end
        P_SQZ: begin
          mop = '{issue: 1'b1, clr: 1'b0, shift: 1'b0};
          ma  = mz;
          mb  = MB_W'(mz);
        end
        P_LO: begin
          mop = '{issue: 1'b1, clr: 1'b1, shift: 1'b0};
          ma  = mac_acc[MA_W-1:0];
          mb  = MB_W'(s2_r);
        end
        P_HI: begin
          mop = '{issue: 1'b1, clr: 1'b0, shift: 1'b1};
          ma  = d2hi_r;
          mb  = MB_W'(s2_r);
        end
        default: ;
      endcase
    end else if (state == ST_LEVEL) begin
      unique case (step)
        L_MULK: begin
          mop = '{issue: 1'b1, clr: 1'b1, shift: 1'b0};
          ma  = MA_W'(sw_rd);
          mb  = MB_W'(k);
        end
        L_TLO: begin
          mop = '{issue: 1'b1, clr: 1'b1, shift: 1'b0};
          ma  = mac_acc[MA_W-1:0];
          mb  = mac_acc[MB_W-1:0];
        end
        L_THI: begin
          mop = '{issue: 1'b1, clr: 1'b0, shift: 1'b1};
          ma  = MA_W'(t_r[MB_W-1:MA_W]);
          mb  = t_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
      hyst  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIST_SCALE: scale <= cfg_data;
        REG_HYST:       hyst  <= cfg_data[HYST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      proxy     <= '0;
      out_valid <= 1'b0;
    end else begin
      proxy <= proxy_next;
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            c_r  <= cluster;
            px   <= pos_x;
            py   <= pos_y;
            pz   <= pos_z;
            step <= '0;
            unique case (kind_t'(kind))
              KIND_QUERY:  state <= ST_PREP;
              KIND_CENTER: state <= ST_CENTER;
              KIND_SWITCH,
              KIND_COUNT:  state <= ST_IDLE;
              default:     state <= ST_IDLE;
            endcase
          end
        end
        ST_CENTER: begin
          state <= ST_IDLE;
        end
        ST_PREP: begin
          if (step == P_SCALE) begin
            mx    <= abs_diff(px, ctr_x);
            my    <= abs_diff(py, ctr_y);
            mz    <= abs_diff(pz, ctr_z);
            act_r <= act_rd;
            cnt_r <= count_rd;
          end
          if (step == P_SQY) begin
            s2_r <= mac_acc[S2_W-1:0];
          end
          if (step == P_LO) begin
            d2hi_r <= mac_acc[2*MA_W-1:MA_W];
          end
          if (step == P_LAST) begin
            lhs_r <= mac_acc;
            step  <= '0;
            if (cnt_r == '0) begin
              target_r <= LVL_NONE;
              state    <= ST_DONE;
            end else begin
              lvl   <= LV_W'(cnt_r - 1'b1);
              state <= ST_LEVEL;
            end
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_LEVEL: begin
          if (step == L_TLO) begin
            t_r <= mac_acc[MB_W-1:0];
          end
          if (step == L_LAST) begin
            step <= '0;
            if (hit) begin
              target_r <= $signed({1'b0, lvl});
              state    <= ST_DONE;
            end else if (lvl == '0) begin
              target_r <= LVL_NONE;
              state    <= ST_DONE;
            end else begin
              lvl <= lvl - 1'b1;
            end
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            cluster_out    <= c_r;
            sel_level      <= target_r;
            changed        <= chg_w;
            active_proxies <= proxy_next;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  lodsel_store u_store (
    .clk         (clk),
    .rst         (rst),
    .ctl         (tctl),
    .cluster     (cluster),
    .level       (level),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .switch_dist (switch_dist),
    .count_wdata (count_sat),
    .act_addr    (c_r),
    .act_wdata   (act_wdata),
    .sw_raddr    ({c_r, lvl}),
    .ctr_x       (ctr_x),
    .ctr_y       (ctr_y),
    .ctr_z       (ctr_z),
    .count_rd    (count_rd),
    .act_rd      (act_rd),
    .sw_rd       (sw_rd)
  );

  lodsel_mac u_mac (
    .clk (clk),
    .rst (rst),
    .op  (mop),
    .a   (ma),
    .b   (mb),
    .acc (mac_acc)
  );

  a_proxy_bound: assert property (@(posedge clk) disable iff (rst)
    proxy <= PROXY_W'(NUM_CLUSTERS))
    else $error("proxy count above cluster count");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result word raised outside completion");

  a_lvl_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LEVEL) |-> ({1'b0, lvl} < cnt_r))
    else $error("level scan beyond level count");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LEVEL) |-> (step <= L_LAST))
    else $error("level step counter overran");

endmodule

// ===== sim/tb_lod_level_select_hysteresis_unit.sv =====
`timescale 1ns / 1ps

module tb_lod_level_select_hysteresis_unit;
  import lodsel_pkg::*;

  typedef struct {
    kind_t                   op;
    logic [CL_W-1:0]         cl;
    logic [LV_W-1:0]         lvl;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
    logic [DIST_W-1:0]       sdist;
    logic [CNT_W-1:0]        cnt;
  } lod_word_t;

  typedef struct {
    logic [CL_W-1:0]         cl;
    logic signed [TGT_W-1:0] tgt;
    logic                    chg;
    logic [PROXY_W-1:0]      proxies;
  } lod_pick_t;

  class lod_selection_tracker;
    logic [SCALE_W-1:0]      scale;
    logic [HYST_W-1:0]       hyst;
    logic signed [POS_W-1:0] ctr_x[NUM_CLUSTERS];
    logic signed [POS_W-1:0] ctr_y[NUM_CLUSTERS];
    logic signed [POS_W-1:0] ctr_z[NUM_CLUSTERS];
    logic [DIST_W-1:0]       sw_dist[NUM_CLUSTERS][NUM_LEVELS];
    logic [CNT_W-1:0]        lvl_cnt[NUM_CLUSTERS];
    logic signed [TGT_W-1:0] active_lvl[NUM_CLUSTERS];
    logic [PROXY_W-1:0]      proxies;
    lod_pick_t               pending_picks[$];
    int                      errors;

    function new();
      scale = SCALE_RESET;
      hyst = '0;
      proxies = '0;
      errors = 0;
      foreach (lvl_cnt[i]) begin
        lvl_cnt[i] = '0;
        active_lvl[i] = LVL_NONE;
        ctr_x[i] = '0;
        ctr_y[i] = '0;
        ctr_z[i] = '0;
      end
      foreach (sw_dist[i, j]) sw_dist[i][j] = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] v);
      if (idx == REG_DIST_SCALE) scale = v;
      else if (idx == REG_HYST) hyst = v[HYST_W-1:0];
    endfunction

    function longint unsigned sq_gap(logic signed [POS_W-1:0] a,
                                     logic signed [POS_W-1:0] b);
      longint g;
      g = longint'(a) - longint'(b);
      if (g < 0) g = -g;
      return g * g;
    endfunction

    // exact squared compare: (d*scale)^2 >= (dist*k)^2
    function void select_level(lod_word_t w);
      logic [127:0] lhs;
      logic [127:0] rhs;
      logic [127:0] thr;
      int act;
      int tgt;
      lod_pick_t p;
      lhs = sq_gap(w.px, ctr_x[w.cl]) + sq_gap(w.py, ctr_y[w.cl]) + sq_gap(w.pz, ctr_z[w.cl]);
      lhs = lhs * scale * scale;
      act = active_lvl[w.cl];
      tgt = -1;
      for (int i = int'(lvl_cnt[w.cl]) - 1; i >= 0; i--) begin
        thr = sw_dist[w.cl][i];
        if (act > i) thr = thr * (256 + hyst);
        else if (act < i) thr = thr * (256 - hyst);
        else thr = thr * 256;
        rhs = thr * thr;
        if (lhs >= rhs) begin
          tgt = i;
          break;
        end
      end
      p.chg = (tgt != act);
      if (p.chg) begin
        if (act < 0 && tgt >= 0) proxies++;
        else if (act >= 0 && tgt < 0 && proxies > 0) proxies--;
        active_lvl[w.cl] = TGT_W'(tgt);
      end
      p.cl = w.cl;
      p.tgt = TGT_W'(tgt);
      p.proxies = proxies;
      pending_picks = {pending_picks, p};
    endfunction

    function void note_word(lod_word_t w);
      case (w.op)
        KIND_CENTER: begin
          ctr_x[w.cl] = w.px;
          ctr_y[w.cl] = w.py;
          ctr_z[w.cl] = w.pz;
          if (active_lvl[w.cl] >= 0 && proxies > 0) proxies--;
          active_lvl[w.cl] = LVL_NONE;
        end
        KIND_SWITCH: sw_dist[w.cl][w.lvl] = w.sdist;
        KIND_COUNT: lvl_cnt[w.cl] = (w.cnt > MAX_COUNT) ? MAX_COUNT : w.cnt;
        default: select_level(w);
      endcase
    endfunction

    function void check_pick(lod_pick_t got);
      lod_pick_t want;
      if (pending_picks.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual cluster %0d level %0d",
                 $time, got.cl, got.tgt);
        errors++;
        return;
      end
      want = pending_picks.pop_front();
      if (got.cl !== want.cl) begin
        $display("%0t: cluster_out expected %0d actual %0d", $time, want.cl, got.cl);
        errors++;
      end
      if (got.tgt !== want.tgt) begin
        $display("%0t: sel_level expected %0d actual %0d", $time, want.tgt, got.tgt);
        errors++;
      end
      if (got.chg !== want.chg) begin
        $display("%0t: changed expected %0d actual %0d", $time, want.chg, got.chg);
        errors++;
      end
      if (got.proxies !== want.proxies) begin
        $display("%0t: active_proxies expected %0d actual %0d",
                 $time, want.proxies, got.proxies);
        errors++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DW-1:0]        cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic [1:0]               kind;
  logic [CL_W-1:0]          cluster;
  logic [LV_W-1:0]          level;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic [DIST_W-1:0]        switch_dist;
  logic [CNT_W-1:0]         count;
  logic                     out_valid;
  logic                     out_stall;
  logic [CL_W-1:0]          cluster_out;
  logic signed [TGT_W-1:0]  sel_level;
  logic                     changed;
  logic [PROXY_W-1:0]       active_proxies;

  lod_selection_tracker sel;
  bit center_set[NUM_CLUSTERS];
  bit dist_set[NUM_CLUSTERS][NUM_LEVELS];
  int in_idle_pct;
  int out_stall_pct;
  bit hold_req;

  lod_level_select_hysteresis_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < out_stall_pct);
      end
    end
  end

  // outputs settle well before the falling edge; the word moves at the next rise
  always @(negedge clk) begin
    lod_pick_t got;
    if (!rst && out_valid && !out_stall) begin
      got.cl = cluster_out;
      got.tgt = sel_level;
      got.chg = changed;
      got.proxies = active_proxies;
      sel.check_pick(got);
    end
  end

  function automatic lod_word_t rand_word();
    lod_word_t w;
    w.op = kind_t'($urandom_range(3));
    w.cl = CL_W'($urandom);
    w.lvl = LV_W'($urandom);
    w.px = POS_W'($urandom);
    w.py = POS_W'($urandom);
    w.pz = POS_W'($urandom);
    w.sdist = DIST_W'($urandom);
    w.cnt = CNT_W'($urandom);
    return w;
  endfunction

  function automatic logic signed [POS_W-1:0] rand_pos();
    if ($urandom_range(99) < 20) return POS_W'($urandom);
    return POS_W'(int'($urandom_range(131071)) - 65536);
  endfunction

  function automatic logic signed [POS_W-1:0] near(logic signed [POS_W-1:0] ctr, int span);
    if ($urandom_range(99) < 15) return POS_W'($urandom);
    return POS_W'(int'(ctr) + int'($urandom_range(2 * span)) - span);
  endfunction

  // first level in use whose switch distance was never loaded, -1 if none
  function automatic int missing_level(int c);
    for (int i = 0; i < int'(sel.lvl_cnt[c]); i++)
      if (!dist_set[c][i]) return i;
    return -1;
  endfunction

  // called after a falling edge; returns at the falling edge before acceptance
  task automatic send_word(lod_word_t w);
    while ($urandom_range(99) < in_idle_pct) begin
      @(posedge clk);
      in_valid <= 1'b0;
      @(negedge clk);
    end
    @(posedge clk);
    in_valid <= 1'b1;
    kind <= w.op;
    cluster <= w.cl;
    level <= w.lvl;
    pos_x <= w.px;
    pos_y <= w.py;
    pos_z <= w.pz;
    switch_dist <= w.sdist;
    count <= w.cnt;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    sel.note_word(w);
    if (w.op == KIND_CENTER) center_set[w.cl] = 1'b1;
    if (w.op == KIND_SWITCH) dist_set[w.cl][w.lvl] = 1'b1;
  endtask

  task automatic put_center(int c, logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                            logic signed [POS_W-1:0] z);
    lod_word_t w;
    w = rand_word();
    w.op = KIND_CENTER;
    w.cl = CL_W'(c);
    w.px = x;
    w.py = y;
    w.pz = z;
    send_word(w);
  endtask

  task automatic put_switch(int c, int l, logic [DIST_W-1:0] d);
    lod_word_t w;
    w = rand_word();
    w.op = KIND_SWITCH;
    w.cl = CL_W'(c);
    w.lvl = LV_W'(l);
    w.sdist = d;
    send_word(w);
  endtask

  task automatic put_count(int c, int n);
    lod_word_t w;
    w = rand_word();
    w.op = KIND_COUNT;
    w.cl = CL_W'(c);
    w.cnt = CNT_W'(n);
    send_word(w);
  endtask

  task automatic ask(int c, logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                     logic signed [POS_W-1:0] z);
    lod_word_t w;
    w = rand_word();
    w.op = KIND_QUERY;
    w.cl = CL_W'(c);
    w.px = x;
    w.py = y;
    w.pz = z;
    send_word(w);
  endtask

  task automatic stop_words();
    @(posedge clk);
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  // writes leave no result, so allow the slowest item to finish as well
  task automatic drain();
    while (sel.pending_picks.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    sel.set_reg(idx, v);
  endtask

  // mostly a small working set so clusters get queried again and again
  task automatic run_phase(int n);
    int c;
    int r;
    int span;
    logic [DIST_W-1:0] sd;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      c = ($urandom_range(3) != 0) ? $urandom_range(7) : $urandom_range(NUM_CLUSTERS - 1);
      r = (r < 70) ? 0 : r;
      r = $urandom_range(99);
      case ($urandom_range(2))
        0: span = 64;
        1: span = 1024;
        default: span = 8192;
      endcase
      if ($urandom_range(99) < 70) sd = DIST_W'($urandom_range(12000));
      else if ($urandom_range(1) == 0) sd = DIST_W'($urandom_range(255));
      else sd = DIST_W'($urandom);
      if (r < 10 || (r >= 25 && !center_set[c]))
        put_center(c, rand_pos(), rand_pos(), rand_pos());
      else if (r < 20)
        put_switch(c, $urandom_range(NUM_LEVELS - 1), sd);
      else if (r >= 25 && missing_level(c) >= 0)
        put_switch(c, missing_level(c), sd);
      else if (r < 25)
        put_count(c, $urandom_range(7));
      else
        ask(c, near(sel.ctr_x[c], span), near(sel.ctr_y[c], span), near(sel.ctr_z[c], span));
    end
  endtask

  initial begin
    logic [SCALE_W-1:0] scales[6];
    logic [HYST_W-1:0]  hysts[6];
    scales = '{16'd256, 16'd65535, 16'd0, 16'd200, 16'd384, 16'd256};
    hysts = '{8'd0, 8'd255, 8'd128, 8'd255, 8'd64, 8'd1};
    sel = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    kind = '0;
    cluster = '0;
    level = '0;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    switch_dist = '0;
    count = '0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_req = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, on reset register values
    put_count(0, 7);
    put_switch(0, 0, 24'h000000);
    put_switch(0, 1, 24'h000400);
    put_switch(0, 2, 24'h001000);
    put_switch(0, 3, 24'hFFFFFF);
    put_center(0, 24'sh000000, 24'sh000000, 24'sh000000);
    ask(0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    ask(0, 24'sh000000, 24'sh000000, 24'sh000000);
    ask(0, 24'sh000000, 24'sh000000, 24'sh000000);
    put_center(63, 24'sh800000, 24'sh800000, 24'sh800000);
    put_count(63, 0);
    ask(63, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    put_switch(63, 0, 24'h555555);
    put_switch(63, 1, 24'hAAAAAA);
    put_count(63, 2);
    ask(63, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    put_count(63, 5);
    put_center(63, 24'sh000000, 24'sh000000, 24'sh000000);
    put_count(0, 0);
    ask(0, 24'sh000001, 24'sh000002, 24'sh000003);
    put_count(1, 1);
    put_switch(1, 0, 24'h000100);
    put_center(1, 24'sh000000, 24'sh000000, 24'sh000000);
    ask(1, 24'sh000100, 24'sh000000, 24'sh000000);
    ask(1, 24'sh0000FF, 24'sh000000, 24'sh000000);

    for (int p = 0; p < 6; p++) begin
      stop_words();
      drain();
      write_reg(REG_DIST_SCALE, scales[p]);
      write_reg(REG_HYST, {8'($urandom), hysts[p]});
      if (p < 2) begin
        in_idle_pct = 22;
        out_stall_pct = 58;
      end else if (p < 4) begin
        in_idle_pct = 58;
        out_stall_pct = 22;
      end else begin
        in_idle_pct = 0;
        out_stall_pct = 0;
      end
      if (p == 4) hold_req = 1'b1;
      run_phase(160);
    end
    stop_words();
    drain();
    if (sel.errors == 0 && sel.pending_picks.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== lod_level_select_hysteresis_unit.f =====
sv/lodsel_pkg.sv
sv/lodsel_mac.sv
sv/lodsel_store.sv
sv/lod_level_select_hysteresis_unit.sv
sim/tb_lod_level_select_hysteresis_unit.sv
